// ----- design/json_byte_tokenizer_unit_assert.svh -----
// Assertion macros shared by the tokenizer checker.
`ifndef JSON_BYTE_TOKENIZER_UNIT_ASSERT_SVH
`define JSON_BYTE_TOKENIZER_UNIT_ASSERT_SVH

// Same-cycle implication, quiet during reset.
`define JBT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet during reset.
`define JBT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define JBT_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/jbt_pkg.sv -----
// Types, field widths and result codes of the JSON byte tokenizer.
package jbt_pkg;

  localparam int OFFSET_BITS = 32;
  localparam int LINE_BITS   = 24;
  localparam int COLUMN_BITS = 16;

  localparam logic [1:0] RES_TOKEN = 2'd0;
  localparam logic [1:0] RES_ERROR = 2'd1;
  localparam logic [1:0] RES_DONE  = 2'd2;

  localparam logic [3:0] TOK_LBRACE   = 4'd0;
  localparam logic [3:0] TOK_RBRACE   = 4'd1;
  localparam logic [3:0] TOK_LBRACKET = 4'd2;
  localparam logic [3:0] TOK_RBRACKET = 4'd3;
  localparam logic [3:0] TOK_COMMA    = 4'd4;
  localparam logic [3:0] TOK_COLON    = 4'd5;
  localparam logic [3:0] TOK_STRING   = 4'd6;
  localparam logic [3:0] TOK_INTEGER  = 4'd7;
  localparam logic [3:0] TOK_DOUBLE   = 4'd8;
  localparam logic [3:0] TOK_BOOLEAN  = 4'd9;
  localparam logic [3:0] TOK_NULL     = 4'd10;
  localparam logic [3:0] TOK_NONE     = 4'd0;

  localparam logic [2:0] ERR_NONE        = 3'd0;
  localparam logic [2:0] ERR_OPEN_STRING = 3'd1;
  localparam logic [2:0] ERR_END_NUMBER  = 3'd2;
  localparam logic [2:0] ERR_BAD_BOOLEAN = 3'd3;
  localparam logic [2:0] ERR_BAD_NULL    = 3'd4;
  localparam logic [2:0] ERR_UNEXPECTED  = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } byte_word_t;

  typedef struct packed {
    logic [1:0]             result_kind;
    logic [3:0]             token_kind;
    logic [2:0]             error_code;
    logic [OFFSET_BITS-1:0] start_offset;
    logic [OFFSET_BITS-1:0] end_offset;
    logic [LINE_BITS-1:0]   line_number;
    logic [COLUMN_BITS-1:0] column_number;
    logic                   last_result;
  } token_word_t;

  // Up to two result words produced by one accepted byte word.
  typedef struct packed {
    logic [1:0]  count;
    token_word_t first;
    token_word_t second;
  } lex_push_t;

endpackage

// ----- design/jbt_lexer.sv -----
// Lexer state and per-byte token logic of the JSON byte tokenizer.
module jbt_lexer (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  jbt_pkg::byte_word_t word,
  output jbt_pkg::lex_push_t push
);
  import jbt_pkg::*;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_STRING,
    MODE_NUMBER,
    MODE_LITERAL,
    MODE_HALT
  } lex_mode_t;

  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_COMMA    = 8'h2C;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_MINUS    = 8'h2D;
  localparam logic [7:0] CH_DOT      = 8'h2E;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_T        = 8'h74;
  localparam logic [7:0] CH_F        = 8'h66;
  localparam logic [7:0] CH_N        = 8'h6E;

  localparam logic [1:0] LIT_TRUE  = 2'd0;
  localparam logic [1:0] LIT_FALSE = 2'd1;
  localparam logic [1:0] LIT_NULL  = 2'd2;

  localparam logic [LINE_BITS-1:0]   LINE_MAX   = '1;
  localparam logic [COLUMN_BITS-1:0] COLUMN_MAX = '1;

  // Expected tail letter of a literal after its first letter.
  function automatic logic [7:0] lit_char(input logic [1:0] k, input logic [1:0] i);
    logic [7:0] c;
    c = 8'h00;
    unique case (k)
      LIT_TRUE: begin
        unique case (i)
          2'd0:    c = 8'h72;
          2'd1:    c = 8'h75;
          2'd2:    c = 8'h65;
          default: c = 8'h00;
        endcase
      end
      LIT_FALSE: begin
        unique case (i)
          2'd0:    c = 8'h61;
          2'd1:    c = 8'h6C;
          2'd2:    c = 8'h73;
          default: c = 8'h65;
        endcase
      end
      default: begin
        unique case (i)
          2'd0:    c = 8'h75;
          2'd1:    c = 8'h6C;
          2'd2:    c = 8'h6C;
          default: c = 8'h00;
        endcase
      end
    endcase
    return c;
  endfunction

  function automatic logic [LINE_BITS-1:0] line_report(input logic [LINE_BITS-1:0] lc);
    return (lc == LINE_MAX) ? LINE_MAX : lc + 1'b1;
  endfunction

  function automatic token_word_t make_word(
    input logic [1:0]             kind,
    input logic [3:0]             tok,
    input logic [2:0]             err,
    input logic [OFFSET_BITS-1:0] s,
    input logic [OFFSET_BITS-1:0] e,
    input logic [LINE_BITS-1:0]   ln,
    input logic [COLUMN_BITS-1:0] col
  );
    token_word_t w;
    w.result_kind   = kind;
    w.token_kind    = tok;
    w.error_code    = err;
    w.start_offset  = s;
    w.end_offset    = e;
    w.line_number   = ln;
    w.column_number = col;
    w.last_result   = 1'b0;
    return w;
  endfunction

  lex_mode_t              mode, mode_next;
  logic [1:0]             literal_kind, literal_kind_next;
  logic [2:0]             literal_index, literal_index_next;
  logic                   seen_dot, seen_dot_next;
  logic                   pending_cr, pending_cr_next;
  logic [OFFSET_BITS-1:0] byte_offset, byte_offset_next;
  logic [LINE_BITS-1:0]   line_counter, line_counter_next;
  logic [COLUMN_BITS-1:0] column_counter, column_counter_next;
  logic [OFFSET_BITS-1:0] token_start, token_start_next;
  logic [LINE_BITS-1:0]   token_line, token_line_next;
  logic [COLUMN_BITS-1:0] token_column, token_column_next;

  always_comb begin
    logic [7:0]             b;
    logic [OFFSET_BITS-1:0] cur;
    logic [LINE_BITS-1:0]   ln_new;
    logic [1:0]             k;
    logic [1:0]             li;
    logic [2:0]             idx_inc;
    logic [2:0]             lit_len;
    logic                   is_digit;
    logic                   is_ws;
    logic                   fresh;
    logic                   num_end;
    logic                   fresh_emit;
    logic                   has_err;
    logic [3:0]             punct;
    logic                   is_punct;
    logic [2:0]             lit_err;
    token_word_t            num_word;
    token_word_t            fresh_word;
    token_word_t            err_word;
    token_word_t            done_word;

    b          = word.data_byte;
    cur        = byte_offset;
    k          = (literal_kind == 2'd3) ? LIT_NULL : literal_kind;
    li         = literal_index[1:0];
    idx_inc    = {1'b0, li} + 3'd1;
    lit_len    = (k == LIT_FALSE) ? 3'd4 : 3'd3;
    lit_err    = (k == LIT_NULL) ? ERR_BAD_NULL : ERR_BAD_BOOLEAN;
    is_digit   = (b >= CH_ZERO) && (b <= CH_NINE);
    is_ws      = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    fresh      = 1'b0;
    num_end    = 1'b0;
    fresh_emit = 1'b0;
    has_err    = 1'b0;
    ln_new     = '0;
    num_word   = '0;
    fresh_word = '0;
    err_word   = '0;
    done_word  = '0;

    unique case (b)
      CH_LBRACE:   begin punct = TOK_LBRACE;   is_punct = 1'b1; end
      CH_RBRACE:   begin punct = TOK_RBRACE;   is_punct = 1'b1; end
      CH_LBRACKET: begin punct = TOK_LBRACKET; is_punct = 1'b1; end
      CH_RBRACKET: begin punct = TOK_RBRACKET; is_punct = 1'b1; end
      CH_COMMA:    begin punct = TOK_COMMA;    is_punct = 1'b1; end
      CH_COLON:    begin punct = TOK_COLON;    is_punct = 1'b1; end
      default:     begin punct = TOK_NONE;     is_punct = 1'b0; end
    endcase

    push                = '0;
    mode_next           = mode;
    literal_kind_next   = literal_kind;
    literal_index_next  = literal_index;
    seen_dot_next       = seen_dot;
    pending_cr_next     = pending_cr;
    byte_offset_next    = byte_offset;
    line_counter_next   = line_counter;
    column_counter_next = column_counter;
    token_start_next    = token_start;
    token_line_next     = token_line;
    token_column_next   = token_column;

    if (accept && word.end_of_input) begin
      // Flush any token in progress as an error, then report done and clear.
      unique case (mode)
        MODE_STRING: begin
          has_err  = 1'b1;
          err_word = make_word(RES_ERROR, TOK_NONE, ERR_OPEN_STRING, token_start,
                               byte_offset - 1'b1, token_line, token_column);
        end
        MODE_NUMBER: begin
          has_err  = 1'b1;
          err_word = make_word(RES_ERROR, TOK_NONE, ERR_END_NUMBER, token_start,
                               byte_offset - 1'b1, token_line, token_column);
        end
        MODE_LITERAL: begin
          has_err  = 1'b1;
          err_word = make_word(RES_ERROR, TOK_NONE, lit_err, token_start,
                               byte_offset - 1'b1, token_line, token_column);
        end
        default: has_err = 1'b0;
      endcase
      done_word = make_word(RES_DONE, TOK_NONE, ERR_NONE, byte_offset, byte_offset,
                            line_report(line_counter), column_counter);
      if (has_err) begin
        push.first  = err_word;
        push.second = done_word;
        push.count  = 2'd2;
      end else begin
        push.first = done_word;
        push.count = 2'd1;
      end
      mode_next           = MODE_IDLE;
      literal_kind_next   = '0;
      literal_index_next  = '0;
      seen_dot_next       = 1'b0;
      pending_cr_next     = 1'b0;
      byte_offset_next    = '0;
      line_counter_next   = '0;
      column_counter_next = '0;
      token_start_next    = '0;
      token_line_next     = '0;
      token_column_next   = '0;
    end else if (accept && (mode != MODE_HALT)) begin
      // Line and column tracking runs in every mode but halt.
      if (b == CH_CR) begin
        if (line_counter != LINE_MAX) line_counter_next = line_counter + 1'b1;
        column_counter_next = '0;
        pending_cr_next     = 1'b1;
      end else if (b == CH_LF) begin
        if (!pending_cr && (line_counter != LINE_MAX)) begin
          line_counter_next = line_counter + 1'b1;
        end
        column_counter_next = '0;
        pending_cr_next     = 1'b0;
      end else begin
        pending_cr_next = 1'b0;
        if (column_counter != COLUMN_MAX) column_counter_next = column_counter + 1'b1;
      end
      byte_offset_next = cur + 1'b1;
      ln_new           = line_report(line_counter_next);

      if (mode == MODE_STRING) begin
        if (b == CH_QUOTE) begin
          push.first = make_word(RES_TOKEN, TOK_STRING, ERR_NONE, token_start, cur,
                                 token_line, token_column);
          push.count = 2'd1;
          mode_next  = MODE_IDLE;
        end
      end else if (mode == MODE_LITERAL) begin
        if (b == lit_char(k, li)) begin
          literal_index_next = idx_inc;
          if (idx_inc == lit_len) begin
            push.first = make_word(RES_TOKEN, (k == LIT_NULL) ? TOK_NULL : TOK_BOOLEAN,
                                   ERR_NONE, token_start, cur, token_line, token_column);
            push.count         = 2'd1;
            mode_next          = MODE_IDLE;
            literal_index_next = '0;
          end
        end else begin
          push.first = make_word(RES_ERROR, TOK_NONE, lit_err, token_start, cur,
                                 token_line, token_column);
          push.count = 2'd1;
          mode_next  = MODE_HALT;
        end
      end else begin
        fresh = 1'b1;
        if (mode == MODE_NUMBER) begin
          if (is_digit || (b == CH_DOT)) begin
            if (b == CH_DOT) seen_dot_next = 1'b1;
            fresh = 1'b0;
          end else begin
            // The terminating byte is lexed again below as a fresh byte.
            num_end  = 1'b1;
            num_word = make_word(RES_TOKEN, seen_dot ? TOK_DOUBLE : TOK_INTEGER,
                                 ERR_NONE, token_start, cur - 1'b1, token_line,
                                 token_column);
          end
        end
        if (fresh) begin
          mode_next = MODE_IDLE;
          if (is_ws) begin
            fresh_emit = 1'b0;
          end else if (is_punct) begin
            fresh_emit = 1'b1;
            fresh_word = make_word(RES_TOKEN, punct, ERR_NONE, cur, cur, ln_new,
                                   column_counter_next);
          end else begin
            token_start_next  = cur;
            token_line_next   = ln_new;
            token_column_next = column_counter_next;
            if (b == CH_QUOTE) begin
              mode_next = MODE_STRING;
            end else if ((b == CH_MINUS) || is_digit) begin
              mode_next     = MODE_NUMBER;
              seen_dot_next = 1'b0;
            end else if ((b == CH_T) || (b == CH_F) || (b == CH_N)) begin
              mode_next          = MODE_LITERAL;
              literal_kind_next  = (b == CH_T) ? LIT_TRUE :
                                   ((b == CH_F) ? LIT_FALSE : LIT_NULL);
              literal_index_next = '0;
            end else begin
              fresh_emit = 1'b1;
              fresh_word = make_word(RES_ERROR, TOK_NONE, ERR_UNEXPECTED, cur, cur,
                                     ln_new, column_counter_next);
              mode_next  = MODE_HALT;
            end
          end
        end
        if (num_end) begin
          push.first  = num_word;
          push.second = fresh_word;
          push.count  = fresh_emit ? 2'd2 : 2'd1;
        end else if (fresh_emit) begin
          push.first = fresh_word;
          push.count = 2'd1;
        end
      end
    end

    // Mark the final word of this byte.
    if (push.count == 2'd1) push.first.last_result = 1'b1;
    if (push.count == 2'd2) push.second.last_result = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_IDLE;
      literal_kind   <= '0;
      literal_index  <= '0;
      seen_dot       <= 1'b0;
      pending_cr     <= 1'b0;
      byte_offset    <= '0;
      line_counter   <= '0;
      column_counter <= '0;
      token_start    <= '0;
      token_line     <= '0;
      token_column   <= '0;
    end else begin
      mode           <= mode_next;
      literal_kind   <= literal_kind_next;
      literal_index  <= literal_index_next;
      seen_dot       <= seen_dot_next;
      pending_cr     <= pending_cr_next;
      byte_offset    <= byte_offset_next;
      line_counter   <= line_counter_next;
      column_counter <= column_counter_next;
      token_start    <= token_start_next;
      token_line     <= token_line_next;
      token_column   <= token_column_next;
    end
  end

endmodule

// ----- design/jbt_result_fifo.sv -----
// Four-word result queue taking up to two words per cycle.
module jbt_result_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  jbt_pkg::lex_push_t   push,
  output logic                 room,
  output logic                 out_valid,
  input  logic                 out_ready,
  output jbt_pkg::token_word_t out_word
);
  import jbt_pkg::*;

  token_word_t slots [4];
  logic [1:0]  head;
  logic [1:0]  tail;
  logic [2:0]  count;
  logic        pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 3'd0);
  assign out_word  = slots[head];
  // Keep space for the worst case of two words from one byte.
  assign room      = (count <= 3'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head + {1'b0, pop};
      tail  <= tail + push.count;
      count <= count + {1'b0, push.count} - {2'b00, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) slots[tail] <= push.first;
    if (push.count == 2'd2) slots[tail + 2'd1] <= push.second;
  end

endmodule

// ----- design/json_byte_tokenizer_unit.sv -----
// Top level of the JSON byte tokenizer: lexer core and result queue.
//
//   channel  handshake                 word           direction
//   byte     byte_valid / byte_ready   byte_word      in  (text byte or end mark)
//   token    token_valid / token_ready token_word     out (token, error or done)
//
// One byte word is taken per cycle while byte_ready is high; all lexing for it
// is done in the cycle it is accepted, and its result words, up to two, land in
// the queue at that edge. A result word shows once those ahead of it are taken.
// byte_ready drops while fewer than two queue slots are free, so a byte that
// ends a number and opens a token, or an end mark after an open token, slows
// intake to the one-word-per-cycle drain of the token side.
// rst is synchronous: it empties the queue and returns the lexer to idle.
module json_byte_tokenizer_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_valid,
  output logic                 byte_ready,
  input  jbt_pkg::byte_word_t  byte_word,
  output logic                 token_valid,
  input  logic                 token_ready,
  output jbt_pkg::token_word_t token_word
);
  import jbt_pkg::*;

  lex_push_t push;
  logic      accept;
  logic      room;

  // Take a byte only when the queue can hold both words it may cause.
  assign byte_ready = room;
  assign accept     = byte_valid && byte_ready;

  // Advance the lexer state and build this byte's result words.
  jbt_lexer u_lexer (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .word   (byte_word),
    .push   (push)
  );

  // Hold result words until the token side takes them.
  jbt_result_fifo u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (token_valid),
    .out_ready (token_ready),
    .out_word  (token_word)
  );

endmodule

// ----- design/jbt_checker.sv -----
// Port-level checks of the JSON byte tokenizer and their binding.
`include "json_byte_tokenizer_unit_assert.svh"

module jbt_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 byte_valid,
  input logic                 byte_ready,
  input jbt_pkg::byte_word_t  byte_word,
  input logic                 token_valid,
  input logic                 token_ready,
  input jbt_pkg::token_word_t token_word
);
  import jbt_pkg::*;

  `JBT_ASSERT_NEXT_ALWAYS(a_reset_empties, rst, !token_valid, "token word after reset")
  `JBT_ASSERT_NEXT(a_stall_holds, token_valid && !token_ready, token_valid && $stable(token_word), "stalled token word changed")
  `JBT_ASSERT_NEXT(a_end_gives_word, byte_valid && byte_ready && byte_word.end_of_input, token_valid, "no result after end mark")
  `JBT_ASSERT_NOW(a_done_is_last, token_valid && (token_word.result_kind == RES_DONE), token_word.last_result && (token_word.start_offset == token_word.end_offset), "malformed done word")

endmodule

bind json_byte_tokenizer_unit jbt_checker u_checker (.*);

// ----- sim/json_byte_tokenizer_unit_tb.sv -----
// Self-checking testbench for the JSON byte tokenizer: directed and random byte streams.
`timescale 1ns / 100ps

module json_byte_tokenizer_unit_tb;
  import jbt_pkg::*;

  // Byte values the lexer gives a meaning to
  localparam logic [7:0] CH_LBRACE   = "{";
  localparam logic [7:0] CH_RBRACE   = "}";
  localparam logic [7:0] CH_LBRACKET = "[";
  localparam logic [7:0] CH_RBRACKET = "]";
  localparam logic [7:0] CH_COMMA    = ",";
  localparam logic [7:0] CH_COLON    = ":";
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_MINUS    = "-";
  localparam logic [7:0] CH_DOT      = ".";
  localparam logic [7:0] CH_ZERO     = "0";
  localparam logic [7:0] CH_NINE     = "9";
  localparam logic [7:0] CH_SPACE    = " ";
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_LF       = 8'h0a;
  localparam logic [7:0] CH_VT       = 8'h0b;
  localparam logic [7:0] CH_FF       = 8'h0c;
  localparam logic [7:0] CH_CR       = 8'h0d;

  localparam int RANDOM_BYTES   = 790;
  localparam int LONG_HOLD      = 400;    // receiver hold-off, in cycles
  localparam int HOLD_AFTER     = 300;    // accepted byte words before the hold-off
  localparam int TAIL_CYCLES    = 20;

  typedef enum logic [2:0] {LX_IDLE, LX_STRING, LX_NUMBER, LX_LITERAL, LX_HALT} lex_state_t;
  typedef enum logic [1:0] {LIT_TRUE, LIT_FALSE, LIT_NULL} lit_kind_t;

  // A byte word waiting to be sent; drain_first holds it back until every
  // expected token word has arrived.
  typedef struct packed {
    logic       drain_first;
    byte_word_t w;
  } pending_word_t;

  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        byte_valid  = 1'b0;
  logic        byte_ready;
  byte_word_t  byte_word   = '0;
  logic        token_valid;
  logic        token_ready = 1'b0;
  token_word_t token_word;

  json_byte_tokenizer_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_ready  (byte_ready),
    .byte_word   (byte_word),
    .token_valid (token_valid),
    .token_ready (token_ready),
    .token_word  (token_word)
  );

  always #5 clk = ~clk;

  pending_word_t byte_words[$];
  token_word_t   expected_tokens[$];
  bit            drain_pending = 1'b0;
  int            mismatch_count = 0;
  int            bytes_taken_count = 0;
  logic          byte_taken = 1'b0;

  // Lexer state mirrored by the predictor
  lex_state_t             lex_state;
  lit_kind_t              lit_kind;
  logic [2:0]             lit_pos;
  logic                   saw_dot;
  logic                   after_cr;
  logic [OFFSET_BITS-1:0] offset_count;
  logic [LINE_BITS-1:0]   line_count;
  logic [COLUMN_BITS-1:0] col_count;
  logic [OFFSET_BITS-1:0] tok_start;
  logic [LINE_BITS-1:0]   tok_line;
  logic [COLUMN_BITS-1:0] tok_col;

  task automatic lexer_clear();
    lex_state    = LX_IDLE;
    lit_kind     = LIT_TRUE;
    lit_pos      = '0;
    saw_dot      = 1'b0;
    after_cr     = 1'b0;
    offset_count = '0;
    line_count   = '0;
    col_count    = '0;
    tok_start    = '0;
    tok_line     = '0;
    tok_col      = '0;
  endtask

  // One-based line, held at the field maximum once the count saturates
  function automatic logic [LINE_BITS-1:0] line_now();
    return (line_count == '1) ? line_count : line_count + 1'b1;
  endfunction

  // Bytes still to match after the first letter of a literal
  function automatic string literal_tail(lit_kind_t k);
    case (k)
      LIT_TRUE:  return "rue";
      LIT_FALSE: return "alse";
      default:   return "ull";
    endcase
  endfunction

  function automatic token_word_t make_word(logic [1:0] kind, logic [3:0] tok,
                                            logic [2:0] err,
                                            logic [OFFSET_BITS-1:0] first,
                                            logic [OFFSET_BITS-1:0] last,
                                            logic [LINE_BITS-1:0] ln,
                                            logic [COLUMN_BITS-1:0] col);
    token_word_t w;
    w.result_kind   = kind;
    w.token_kind    = tok;
    w.error_code    = err;
    w.start_offset  = first;
    w.end_offset    = last;
    w.line_number   = ln;
    w.column_number = col;
    w.last_result   = 1'b0;
    return w;
  endfunction

  function automatic string word_text(token_word_t w);
    return $sformatf("kind=%0d tok=%0d err=%0d start=%0d end=%0d line=%0d col=%0d last=%0d",
                     w.result_kind, w.token_kind, w.error_code, w.start_offset,
                     w.end_offset, w.line_number, w.column_number, w.last_result);
  endfunction

  // Lex one accepted byte word and queue the token words it should cause
  task automatic lex_byte_word(input byte_word_t w);
    token_word_t            made[$];
    logic [7:0]             b;
    logic [OFFSET_BITS-1:0] here;
    logic [LINE_BITS-1:0]   ln;
    logic [COLUMN_BITS-1:0] col;
    logic [3:0]             punct;
    logic                   is_punct;
    logic                   fresh;
    string                  tail;
    b    = w.data_byte;
    here = offset_count;
    if (w.end_of_input) begin
      // Report any token left open, then the done word; start afresh
      case (lex_state)
        LX_STRING:  made.push_back(make_word(RES_ERROR, TOK_NONE, ERR_OPEN_STRING,
                                             tok_start, here - 1'b1, tok_line, tok_col));
        LX_NUMBER:  made.push_back(make_word(RES_ERROR, TOK_NONE, ERR_END_NUMBER,
                                             tok_start, here - 1'b1, tok_line, tok_col));
        LX_LITERAL: made.push_back(make_word(RES_ERROR, TOK_NONE,
                                             (lit_kind == LIT_NULL) ? ERR_BAD_NULL
                                                                    : ERR_BAD_BOOLEAN,
                                             tok_start, here - 1'b1, tok_line, tok_col));
        default: ;
      endcase
      made.push_back(make_word(RES_DONE, TOK_NONE, ERR_NONE, here, here, line_now(),
                               col_count));
      lexer_clear();
    end else if (lex_state != LX_HALT) begin
      // Line and column advance in every mode but halt, strings included
      if (b == CH_CR) begin
        if (line_count != '1) line_count = line_count + 1'b1;
        col_count = '0;
        after_cr  = 1'b1;
      end else if (b == CH_LF) begin
        if (!after_cr && line_count != '1) line_count = line_count + 1'b1;
        col_count = '0;
        after_cr  = 1'b0;
      end else begin
        after_cr = 1'b0;
        if (col_count != '1) col_count = col_count + 1'b1;
      end
      offset_count = here + 1'b1;

      case (lex_state)
        LX_STRING: begin
          if (b == CH_QUOTE) begin
            made.push_back(make_word(RES_TOKEN, TOK_STRING, ERR_NONE, tok_start, here,
                                     tok_line, tok_col));
            lex_state = LX_IDLE;
          end
        end
        LX_LITERAL: begin
          tail = literal_tail(lit_kind);
          if (b == tail[lit_pos]) begin
            lit_pos = lit_pos + 1'b1;
            if (lit_pos >= tail.len()) begin
              made.push_back(make_word(RES_TOKEN,
                                       (lit_kind == LIT_NULL) ? TOK_NULL : TOK_BOOLEAN,
                                       ERR_NONE, tok_start, here, tok_line, tok_col));
              lex_state = LX_IDLE;
              lit_pos   = '0;
            end
          end else begin
            // Consume the mismatching byte, report and halt
            made.push_back(make_word(RES_ERROR, TOK_NONE,
                                     (lit_kind == LIT_NULL) ? ERR_BAD_NULL : ERR_BAD_BOOLEAN,
                                     tok_start, here, tok_line, tok_col));
            lex_state = LX_HALT;
          end
        end
        default: begin
          fresh = 1'b1;
          if (lex_state == LX_NUMBER) begin
            if ((b >= CH_ZERO && b <= CH_NINE) || b == CH_DOT) begin
              if (b == CH_DOT) saw_dot = 1'b1;
              fresh = 1'b0;
            end else begin
              // Close the number; its terminator is lexed below as a new byte
              made.push_back(make_word(RES_TOKEN, saw_dot ? TOK_DOUBLE : TOK_INTEGER,
                                       ERR_NONE, tok_start, here - 1'b1, tok_line,
                                       tok_col));
              lex_state = LX_IDLE;
            end
          end
          if (fresh) begin
            ln       = line_now();
            col      = col_count;
            punct    = TOK_NONE;
            is_punct = 1'b1;
            case (b)
              CH_LBRACE:   punct = TOK_LBRACE;
              CH_RBRACE:   punct = TOK_RBRACE;
              CH_LBRACKET: punct = TOK_LBRACKET;
              CH_RBRACKET: punct = TOK_RBRACKET;
              CH_COMMA:    punct = TOK_COMMA;
              CH_COLON:    punct = TOK_COLON;
              default:     is_punct = 1'b0;
            endcase
            lex_state = LX_IDLE;
            if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR)) begin
              // whitespace: nothing to report
            end else if (is_punct) begin
              made.push_back(make_word(RES_TOKEN, punct, ERR_NONE, here, here, ln, col));
            end else begin
              tok_start = here;
              tok_line  = ln;
              tok_col   = col;
              if (b == CH_QUOTE) begin
                lex_state = LX_STRING;
              end else if (b == CH_MINUS || (b >= CH_ZERO && b <= CH_NINE)) begin
                lex_state = LX_NUMBER;
                saw_dot   = 1'b0;
              end else if (b == "t" || b == "f" || b == "n") begin
                lex_state = LX_LITERAL;
                lit_kind  = (b == "t") ? LIT_TRUE : ((b == "f") ? LIT_FALSE : LIT_NULL);
                lit_pos   = '0;
              end else begin
                made.push_back(make_word(RES_ERROR, TOK_NONE, ERR_UNEXPECTED, here, here,
                                         ln, col));
                lex_state = LX_HALT;
              end
            end
          end
        end
      endcase
    end
    if (made.size() > 0) made[made.size()-1].last_result = 1'b1;
    foreach (made[i]) expected_tokens.push_back(made[i]);
  endtask

  // Stimulus queue helpers
  task automatic push_byte(input logic [7:0] b);
    pending_word_t p;
    p.drain_first    = drain_pending;
    p.w.data_byte    = b;
    p.w.end_of_input = 1'b0;
    drain_pending    = 1'b0;
    byte_words.push_back(p);
  endtask

  task automatic push_end();
    pending_word_t p;
    p.drain_first    = drain_pending;
    p.w.data_byte    = 8'($urandom_range(0, 255));
    p.w.end_of_input = 1'b1;
    drain_pending    = 1'b0;
    byte_words.push_back(p);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  // Sampling at the rising edge: predict on every accepted byte word and
  // check every accepted token word against the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      byte_taken <= 1'b0;
      lexer_clear();
    end else begin
      byte_taken <= byte_valid && byte_ready;
      if (byte_valid && byte_ready) begin
        lex_byte_word(byte_word);
        bytes_taken_count++;
      end
      if (token_valid && token_ready) begin
        if (expected_tokens.size() == 0) begin
          mismatch_count++;
          $display("%0t: token word with nothing expected\n  expected none\n  actual   %s",
                   $time, word_text(token_word));
        end else begin
          if (token_word !== expected_tokens[0]) begin
            mismatch_count++;
            $display("%0t: token word mismatch\n  expected %s\n  actual   %s", $time,
                     word_text(expected_tokens[0]), word_text(token_word));
          end
          void'(expected_tokens.pop_front());
        end
      end
    end
  end

  // Sender: bursts of random length with random gaps, driven at the falling edge
  int            burst_left = 1;
  int            gap_left   = 0;
  pending_word_t next_word;

  always @(negedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
      byte_word  <= '0;
      burst_left  = 1;
      gap_left    = 0;
    end else if (!(byte_valid && !byte_taken)) begin
      // Previous word taken, or none on offer: pick what comes next
      if (gap_left != 0) begin
        gap_left--;
        byte_valid <= 1'b0;
      end else if (byte_words.size() == 0 ||
                   (byte_words[0].drain_first && expected_tokens.size() != 0)) begin
        byte_valid <= 1'b0;
      end else begin
        next_word   = byte_words.pop_front();
        byte_word  <= next_word.w;
        byte_valid <= 1'b1;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // Receiver: stretches of steady, light and heavy stalling, plus one long
  // hold-off so that the result queue fills and byte_ready drops.
  int hold_off_left  = 0;
  int stretch_left   = 0;
  int stretch_mode   = 0;
  bit long_hold_done = 1'b0;

  always @(negedge clk) begin
    if (rst) begin
      token_ready <= 1'b0;
    end else if (hold_off_left != 0) begin
      hold_off_left--;
      token_ready <= 1'b0;
    end else if (!long_hold_done && bytes_taken_count >= HOLD_AFTER) begin
      long_hold_done = 1'b1;
      hold_off_left  = LONG_HOLD - 1;
      token_ready   <= 1'b0;
    end else begin
      if (stretch_left == 0) begin
        stretch_mode = $urandom_range(0, 2);
        stretch_left = $urandom_range(5, 60);
      end
      stretch_left--;
      case (stretch_mode)
        0:       token_ready <= 1'b1;
        1:       token_ready <= ($urandom_range(0, 3) != 0);
        default: token_ready <= ($urandom_range(0, 1) != 0);
      endcase
    end
  end

  initial begin
    #30000000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    string      lit_text;
    logic [7:0] b;
    int         pick;
    int         k;
    int         start_size;
    bit         paused_mid;

    // Directed: every punctuation mark, string holding CR LF, double and
    // integer each ended by punctuation (two words from one byte), CRLF
    drain_pending = 1'b1;
    push_text("{\"a\015\012\":[-1.5,7]}\015\012");
    push_end();
    // Booleans, null, CR CR LF, then a literal left open at end of input
    push_text(" true,false\012null\015\015\012n");
    push_end();
    // Bad boolean byte, then a byte ignored while halted
    push_text("fx@");
    push_end();
    // Number at end of input; number ended by an unexpected byte
    push_text("-12");
    push_end();
    push_text("3x");
    push_end();
    // Number ended by a quote, leaving the string open at end of input
    push_text("5\"");
    push_end();
    // Top and bottom byte values, both unexpected (the second is ignored)
    push_byte(8'hff);
    push_byte(8'h00);
    push_end();
    push_end();

    // Random: mostly well-formed token runs, the rest broken literals and noise
    drain_pending = 1'b1;
    paused_mid    = 1'b0;
    start_size    = byte_words.size();
    while (byte_words.size() - start_size < RANDOM_BYTES) begin
      if (!paused_mid && byte_words.size() - start_size >= RANDOM_BYTES / 2) begin
        paused_mid    = 1'b1;
        drain_pending = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        case ($urandom_range(0, 5))
          0:       push_byte(CH_LBRACE);
          1:       push_byte(CH_RBRACE);
          2:       push_byte(CH_LBRACKET);
          3:       push_byte(CH_RBRACKET);
          4:       push_byte(CH_COMMA);
          default: push_byte(CH_COLON);
        endcase
      end else if (pick < 40) begin
        push_byte(CH_QUOTE);
        repeat ($urandom_range(0, 8)) begin
          if ($urandom_range(0, 9) == 0) begin
            b = $urandom_range(0, 1) ? CH_CR : CH_LF;
          end else begin
            do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE);
          end
          push_byte(b);
        end
        // Now and then leave the string open at end of input
        if ($urandom_range(0, 7) == 0) push_end();
        else push_byte(CH_QUOTE);
      end else if (pick < 55) begin
        if ($urandom_range(0, 2) == 0) push_byte(CH_MINUS);
        repeat ($urandom_range(1, 5)) push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
        if ($urandom_range(0, 2) == 0) begin
          push_byte(CH_DOT);
          repeat ($urandom_range(0, 3)) push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
        end
      end else if (pick < 65) begin
        case ($urandom_range(0, 2))
          0:       push_text("true");
          1:       push_text("false");
          default: push_text("null");
        endcase
      end else if (pick < 77) begin
        repeat ($urandom_range(1, 3)) begin
          case ($urandom_range(0, 5))
            0:       push_byte(CH_SPACE);
            1:       push_byte(CH_TAB);
            2:       push_byte(CH_LF);
            3:       push_byte(CH_VT);
            4:       push_byte(CH_FF);
            default: push_byte(CH_CR);
          endcase
        end
      end else if (pick < 85) begin
        push_end();
      end else if (pick < 92) begin
        // Literal cut short by a random byte, then end of input
        case ($urandom_range(0, 2))
          0:       lit_text = "true";
          1:       lit_text = "false";
          default: lit_text = "null";
        endcase
        k = $urandom_range(1, lit_text.len() - 1);
        for (int i = 0; i < k; i++) push_byte(lit_text[i]);
        push_byte(8'($urandom_range(0, 255)));
        push_end();
      end else begin
        push_byte(8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 2)) push_byte(8'($urandom_range(0, 255)));
        push_end();
      end
    end
    push_end();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Hold until every byte word is taken and every token word has arrived
    while (byte_words.size() != 0 || byte_valid) @(posedge clk);
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
